// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/u8cw_pkg.sv =====
`default_nettype none

package u8cw_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int TOTAL_W = 16;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_INVALID_BYTE    = 3'd1,
    ST_UNEXPECTED_CONT = 3'd2,
    ST_OVERLONG        = 3'd3,
    ST_INVALID_CP      = 3'd4,
    ST_TRUNCATED       = 3'd5
  } status_t;

  typedef struct packed {
    logic [20:0]        codepoint;
    logic [2:0]         sequence_length;
    logic [1:0]         char_width;
    status_t            status;
    logic [TOTAL_W-1:0] column_total;
    logic [TOTAL_W-1:0] codepoint_total;
    logic [TOTAL_W-1:0] byte_total;
    logic [TOTAL_W-1:0] fit_prefix_bytes;
    logic               end_of_string;
  } res_t;

  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [20:0] SUR_LO     = 21'h00d800;
  localparam logic [20:0] SUR_HI     = 21'h00dfff;
  localparam logic [20:0] MIN_CP_2   = 21'h000080;
  localparam logic [20:0] MIN_CP_3   = 21'h000800;
  localparam logic [20:0] MIN_CP_4   = 21'h010000;
  localparam logic [20:0] ASCII_DEL  = 21'h00007f;
  localparam logic [20:0] C1_END     = 21'h0000a0;

  localparam int N_ZERO = 9;
  localparam logic [20:0] ZERO_LO [N_ZERO] = '{
    21'h0300, 21'h0610, 21'h064b, 21'h200b, 21'hfeff,
    21'h1ab0, 21'h1dc0, 21'h20d0, 21'hfe20
  };
  localparam logic [20:0] ZERO_HI [N_ZERO] = '{
    21'h036f, 21'h061a, 21'h065f, 21'h200d, 21'hfeff,
    21'h1aff, 21'h1dff, 21'h20ff, 21'hfe2f
  };

  localparam int N_WIDE = 17;
  localparam logic [20:0] WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02e80, 21'h03041, 21'h03400, 21'h04e00, 21'h0a000,
    21'h0a960, 21'h0ac00, 21'h0f900, 21'h0fe10, 21'h0fe30, 21'h0ff01,
    21'h0ffe0, 21'h1b000, 21'h1f004, 21'h1f300, 21'h20000
  };
  localparam logic [20:0] WIDE_HI [N_WIDE] = '{
    21'h0115f, 21'h0303e, 21'h033bf, 21'h04dbf, 21'h09fff, 21'h0a4cf,
    21'h0a97f, 21'h0d7ff, 21'h0faff, 21'h0fe1f, 21'h0fe6f, 21'h0ff60,
    21'h0ffe6, 21'h1b0ff, 21'h1f0cf, 21'h1f9ff, 21'h2fa1f
  };

  function automatic logic [1:0] char_columns(input logic [20:0] cp);
    logic       zero_hit;
    logic       wide_hit;
    logic [1:0] cols;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) zero_hit = 1'b1;
    end
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) wide_hit = 1'b1;
    end
    if (cp == '0)              cols = 2'd0;
    else if (cp < ASCII_DEL)   cols = 2'd1;
    else if (cp < C1_END)      cols = 2'd0;
    else if (zero_hit)         cols = 2'd0;
    else if (wide_hit)         cols = 2'd2;
    else                       cols = 2'd1;
    return cols;
  endfunction

endpackage

`default_nettype wire

// ===== sv/u8cw_if.sv =====
`default_nettype none

interface u8cw_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface u8cw_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic [2:0]  sequence_length;
  logic [1:0]  char_width;
  logic [2:0]  status;
  logic [15:0] column_total;
  logic [15:0] codepoint_total;
  logic [15:0] byte_total;
  logic [15:0] fit_prefix_bytes;
  logic        end_of_string;
  modport source (output valid, codepoint, sequence_length, char_width, status,
    column_total, codepoint_total, byte_total, fit_prefix_bytes, end_of_string,
    input ready);
  modport sink (input valid, codepoint, sequence_length, char_width, status,
    column_total, codepoint_total, byte_total, fit_prefix_bytes, end_of_string,
    output ready);
endinterface

interface u8cw_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] column_limit;
  modport source (output valid, column_limit, input ready);
  modport sink (input valid, column_limit, output ready);
endinterface

`default_nettype wire

// ===== sv/u8cw_decode.sv =====
`default_nettype none
`include "assert_macros.svh"

module u8cw_decode #(
  parameter int COUNT_BITS = u8cw_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [15:0]       column_limit,
  output logic                   produced,
  output u8cw_pkg::res_t         res
);
  import u8cw_pkg::*;

  localparam int EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam int CMP_W = EXT_W + 1;

  logic [1:0]            bytes_remaining, bytes_remaining_next;
  logic [2:0]            sequence_size, sequence_size_next;
  logic [20:0]           accumulated_value, accumulated_value_next;
  logic                  bad_continuation_seen, bad_continuation_seen_next;
  status_t               latched_error, latched_error_next;
  logic [COUNT_BITS-1:0] running_columns, running_columns_next;
  logic [COUNT_BITS-1:0] running_codepoints, running_codepoints_next;
  logic [COUNT_BITS-1:0] running_bytes, running_bytes_next;
  logic [COUNT_BITS-1:0] prefix_bytes, prefix_bytes_next;
  logic                  prefix_closed, prefix_closed_next;

  logic        is_cont;
  logic        take_cp;
  logic        take_err;
  status_t     err_code;
  logic [20:0] cp_val;
  logic [2:0]  cp_len;
  logic [20:0] acc_shift;
  logic [20:0] min_cp;
  logic [1:0]  cols;
  logic [CMP_W-1:0] cols_sum;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                   input logic [2:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS+1)'(b);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[TOTAL_W-1:0];
  endfunction

  assign is_cont   = (data_byte[7:6] == 2'b10);
  assign acc_shift = {accumulated_value[14:0], data_byte[5:0]};
  assign cols      = char_columns(cp_val);
  assign cols_sum  = CMP_W'(running_columns) + CMP_W'(cols);

  always_comb begin
    case (sequence_size)
      3'd2:    min_cp = MIN_CP_2;
      3'd3:    min_cp = MIN_CP_3;
      default: min_cp = MIN_CP_4;
    endcase
  end

  // classify the beat against the current sequence state
  always_comb begin
    bytes_remaining_next       = bytes_remaining;
    sequence_size_next         = sequence_size;
    accumulated_value_next     = accumulated_value;
    bad_continuation_seen_next = bad_continuation_seen;
    take_cp  = 1'b0;
    take_err = 1'b0;
    err_code = ST_OK;
    cp_val   = '0;
    cp_len   = '0;
    produced = 1'b0;
    if (latched_error != ST_OK) begin
      produced = last_byte;
    end else if (bytes_remaining == 2'd0) begin
      if (is_cont) begin
        take_err = 1'b1;
        err_code = ST_UNEXPECTED_CONT;
      end else if (!data_byte[7]) begin
        take_cp = 1'b1;
        cp_val  = {13'd0, data_byte};
        cp_len  = 3'd1;
      end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                   data_byte[7:3] == 5'b11110) begin
        if (data_byte[7:5] == 3'b110) begin
          sequence_size_next     = 3'd2;
          bytes_remaining_next   = 2'd1;
          accumulated_value_next = {16'd0, data_byte[4:0]};
        end else if (data_byte[7:4] == 4'b1110) begin
          sequence_size_next     = 3'd3;
          bytes_remaining_next   = 2'd2;
          accumulated_value_next = {17'd0, data_byte[3:0]};
        end else begin
          sequence_size_next     = 3'd4;
          bytes_remaining_next   = 2'd3;
          accumulated_value_next = {18'd0, data_byte[2:0]};
        end
        bad_continuation_seen_next = 1'b0;
        if (last_byte) begin
          take_err = 1'b1;
          err_code = ST_TRUNCATED;
        end
      end else begin
        take_err = 1'b1;
        err_code = ST_INVALID_BYTE;
      end
    end else begin
      bad_continuation_seen_next = bad_continuation_seen | ~is_cont;
      accumulated_value_next     = acc_shift;
      bytes_remaining_next       = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        if (bad_continuation_seen_next) begin
          take_err = 1'b1;
          err_code = ST_INVALID_BYTE;
        end else if (acc_shift < min_cp) begin
          take_err = 1'b1;
          err_code = ST_OVERLONG;
        end else if ((acc_shift >= SUR_LO && acc_shift <= SUR_HI) || acc_shift > CP_MAX) begin
          take_err = 1'b1;
          err_code = ST_INVALID_CP;
        end else begin
          take_cp = 1'b1;
          cp_val  = acc_shift;
          cp_len  = sequence_size;
        end
      end else if (last_byte) begin
        take_err = 1'b1;
        err_code = ST_TRUNCATED;
      end
    end
    if (take_err) begin
      bytes_remaining_next = 2'd0;
      produced             = 1'b1;
    end
    if (take_cp) produced = 1'b1;
  end

  // totals and prefix
  always_comb begin
    latched_error_next      = take_err ? err_code : latched_error;
    running_columns_next    = running_columns;
    running_codepoints_next = running_codepoints;
    running_bytes_next      = running_bytes;
    prefix_bytes_next       = prefix_bytes;
    prefix_closed_next      = prefix_closed;
    if (take_cp) begin
      if (!prefix_closed) begin
        if (cols_sum > CMP_W'(column_limit)) prefix_closed_next = 1'b1;
        else prefix_bytes_next = sat_add(prefix_bytes, cp_len);
      end
      running_columns_next    = sat_add(running_columns, {1'b0, cols});
      running_codepoints_next = sat_add(running_codepoints, 3'd1);
      running_bytes_next      = sat_add(running_bytes, cp_len);
    end
  end

  always_comb begin
    res.codepoint        = take_cp ? cp_val : '0;
    res.sequence_length  = take_cp ? cp_len : '0;
    res.char_width       = take_cp ? cols : '0;
    res.status           = take_err ? err_code : latched_error;
    res.column_total     = to_total(running_columns_next);
    res.codepoint_total  = to_total(running_codepoints_next);
    res.byte_total       = to_total(running_bytes_next);
    res.fit_prefix_bytes = to_total(prefix_bytes_next);
    res.end_of_string    = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      bytes_remaining       <= '0;
      sequence_size         <= '0;
      accumulated_value     <= '0;
      bad_continuation_seen <= 1'b0;
      latched_error         <= ST_OK;
      running_columns       <= '0;
      running_codepoints    <= '0;
      running_bytes         <= '0;
      prefix_bytes          <= '0;
      prefix_closed         <= 1'b0;
    end else if (fire) begin
      bytes_remaining       <= bytes_remaining_next;
      sequence_size         <= sequence_size_next;
      accumulated_value     <= accumulated_value_next;
      bad_continuation_seen <= bad_continuation_seen_next;
      latched_error         <= latched_error_next;
      running_columns       <= running_columns_next;
      running_codepoints    <= running_codepoints_next;
      running_bytes         <= running_bytes_next;
      prefix_bytes          <= prefix_bytes_next;
      prefix_closed         <= prefix_closed_next;
    end
  end

  `ASSERT_IMPL(a_err_no_seq, clk, rst, latched_error != ST_OK, bytes_remaining == 2'd0)
  `ASSERT_IMPL(a_ok_has_len, clk, rst, produced && res.status == ST_OK,
               res.sequence_length != 3'd0 || latched_error != ST_OK)
  `ASSERT_NEXT(a_last_clears, clk, rst, fire && last_byte,
               running_columns == '0 && latched_error == ST_OK && bytes_remaining == 2'd0)

endmodule

`default_nettype wire

// ===== sv/utf8_decode_column_width_unit.sv =====
// utf-8 decoder, validator and column-width meter
//
// text: one string byte per beat, last_byte set on the final byte of a string.
// result: at most one beat per text beat, for a finished codepoint, for the
//   first error of a string, and always for a byte flagged last_byte. totals
//   run over the current string and return to zero after its last byte.
// cfg: writes column_limit; ready is always high. write it only while idle.
//
// path: a text beat taken into the input register goes through the decode
//   logic into the result register, which drives result.
// throughput: one byte per cycle while result is not held; the sequence
//   state loops through decode logic only, so bytes follow without gaps.
// stall: while result is held the result register keeps its beat and the
//   input register holds one more byte, then text.ready drops.
// reset: synchronous; clears the valid flags of both registers, all string
//   state, and sets column_limit to 65535.
`default_nettype none
`include "assert_macros.svh"

module utf8_decode_column_width_unit #(
  parameter int COUNT_BITS = u8cw_pkg::COUNT_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  u8cw_text_if.sink      text,
  u8cw_result_if.source  result,
  u8cw_cfg_if.sink       cfg
);
  import u8cw_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        r_valid;
  res_t        res_q;
  res_t        res_d;
  logic        produced;
  logic        advance;
  logic        fire;
  logic [15:0] column_limit;

  assign advance    = !r_valid || result.ready;
  assign fire       = s1_valid && advance;
  assign text.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_limit <= 16'hffff;
    end else if (cfg.valid) begin
      column_limit <= cfg.column_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.data_byte;
      s1_last <= text.last_byte;
    end
  end

  u8cw_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .data_byte    (s1_byte),
    .last_byte    (s1_last),
    .column_limit (column_limit),
    .produced     (produced),
    .res          (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= fire && produced;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produced) begin
      res_q <= res_d;
    end
  end

  assign result.valid            = r_valid;
  assign result.codepoint        = res_q.codepoint;
  assign result.sequence_length  = res_q.sequence_length;
  assign result.char_width       = res_q.char_width;
  assign result.status           = res_q.status;
  assign result.column_total     = res_q.column_total;
  assign result.codepoint_total  = res_q.codepoint_total;
  assign result.byte_total       = res_q.byte_total;
  assign result.fit_prefix_bytes = res_q.fit_prefix_bytes;
  assign result.end_of_string    = res_q.end_of_string;

  `ASSERT_NEXT(a_hold_input, clk, rst, s1_valid && !advance, s1_valid)
  `ASSERT_NEXT(a_result_loads, clk, rst, fire && produced, r_valid)
  `ASSERT_IMPL(a_empty_ready, clk, rst, !s1_valid, text.ready)

endmodule

`default_nettype wire
